[design/lsb_stego_embed_extract_unit_defines.svh]
// assertion macros shared by the lsb steganography checker
`ifndef LSB_STEGO_EMBED_EXTRACT_UNIT_DEFINES_SVH
`define LSB_STEGO_EMBED_EXTRACT_UNIT_DEFINES_SVH

// implication checked only while out of reset
`define LSE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lse check failed");

// next-cycle implication checked only while out of reset
`define LSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lse check failed");

// next-cycle implication that also holds through reset
`define LSE_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("lse reset check failed");

`endif

[design/lse_pkg.sv]
// shared constants, types and helpers for the lsb steganography unit
package lse_pkg;

    localparam int MSG_BYTES     = 256;
    localparam int ADDR_W        = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
    localparam int LEN_W         = $clog2(MSG_BYTES + 1);
    localparam int PTR_W         = LEN_W + 3;
    localparam int BITS_PER_BYTE = 8;

    localparam int CMD_W     = 2;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 40;

    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd2;

    localparam logic MODE_EMBED   = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    localparam logic [7:0] LSB_CLEAR  = 8'hFE;
    localparam logic [7:0] PRINT_LOW  = 8'd32;
    localparam logic [7:0] PRINT_HIGH = 8'd126;

    typedef struct packed {
        logic [1:0] n_bits;
        logic [2:0] bit_off;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       byte_valid;
        logic [7:0] rbyte;
        logic       mend;
        logic       big;
        logic       perr;
    } lse_meta_t;

    function automatic logic is_printable(input logic [7:0] b);
        return (b >= PRINT_LOW) && (b <= PRINT_HIGH);
    endfunction

endpackage

[design/lse_msg_ram.sv]
// message store: one write port, two registered read ports
module lse_msg_ram (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [lse_pkg::ADDR_W-1:0] wr_addr,
    input  logic [7:0]                wr_data,
    input  logic                      rd_en,
    input  logic [lse_pkg::ADDR_W-1:0] rd_addr_a,
    input  logic [lse_pkg::ADDR_W-1:0] rd_addr_b,
    output logic [7:0]                rd_data_a,
    output logic [7:0]                rd_data_b
);
    import lse_pkg::*;

    logic [7:0] mem [MSG_BYTES];
    logic [7:0] rd_data_a_reg;
    logic [7:0] rd_data_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while no new pixel is issued
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a_reg <= mem[rd_addr_a];
            rd_data_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

[design/lse_ctrl.sv]
// command decode, pointer and extraction state, store addressing
module lse_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    input  logic                       cfg_data,
    input  logic                       s_fire,
    input  logic [lse_pkg::CMD_W-1:0]  cmd,
    input  logic [7:0]                 msg_byte,
    input  logic [7:0]                 red,
    input  logic [7:0]                 green,
    input  logic [7:0]                 blue,
    input  logic                       last,
    output logic                       wr_en,
    output logic [lse_pkg::ADDR_W-1:0] wr_addr,
    output logic [7:0]                 wr_data,
    output logic                       rd_en,
    output logic [lse_pkg::ADDR_W-1:0] rd_addr_a,
    output logic [lse_pkg::ADDR_W-1:0] rd_addr_b,
    output logic                       issue,
    output lse_pkg::lse_meta_t         meta
);
    import lse_pkg::*;

    logic             mode_reg, mode_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [7:0]       acc_reg, acc_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic             stop_reg, stop_next;

    logic [PTR_W-1:0]  total;
    logic [PTR_W-1:0]  remain;
    logic [1:0]        n_emb;
    logic [PTR_W-1:0]  ptr_emb;
    logic              big;
    logic [ADDR_W-1:0] idx;
    logic              is_embed;
    logic              room;

    logic [2:0] lsb;
    logic [7:0] acc_x;
    logic [2:0] cnt_x;
    logic       stop_x;
    logic       xv;
    logic [7:0] xb;
    logic       xm;
    logic       xp;

    assign is_embed = (mode_reg == MODE_EMBED);
    assign room     = (len_reg < LEN_W'(MSG_BYTES));

    // embed: up to three bits from the current pointer
    assign total   = {len_reg, 3'b000};
    assign remain  = total - ptr_reg;
    assign n_emb   = (remain >= PTR_W'(3)) ? 2'd3 : remain[1:0];
    assign ptr_emb = ptr_reg + PTR_W'(n_emb);
    assign big     = last && (ptr_emb != total);
    assign idx     = ptr_reg[3 +: ADDR_W];

    // a pixel may straddle two bytes, so fetch both
    assign rd_addr_a = idx;
    assign rd_addr_b = (idx == ADDR_W'(MSG_BYTES - 1)) ? '0 : idx + 1'b1;

    assign lsb = {blue[0], green[0], red[0]};

    // extract: shift red, green, blue lsbs in order
    always_comb begin
        acc_x  = acc_reg;
        cnt_x  = cnt_reg;
        stop_x = stop_reg;
        xv     = 1'b0;
        xb     = 8'd0;
        xm     = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (!stop_x) begin
                acc_x = {acc_x[6:0], lsb[k]};
                if (cnt_x == 3'(BITS_PER_BYTE - 1)) begin
                    if (is_printable(acc_x)) begin
                        xv = 1'b1;
                        xb = acc_x;
                    end else begin
                        xm     = 1'b1;
                        stop_x = 1'b1;
                    end
                    acc_x = 8'd0;
                    cnt_x = 3'd0;
                end else begin
                    cnt_x = cnt_x + 3'd1;
                end
            end
        end
        xp = last && !stop_x && (cnt_x != 3'd0);
    end

    always_comb begin
        mode_next = cfg_valid ? cfg_data : mode_reg;
        len_next  = len_reg;
        ptr_next  = ptr_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        stop_next = stop_reg;
        if (s_fire) begin
            case (cmd)
                CMD_START: begin
                    len_next  = '0;
                    ptr_next  = '0;
                    acc_next  = 8'd0;
                    cnt_next  = 3'd0;
                    stop_next = 1'b0;
                end
                CMD_LOAD: begin
                    if (room) begin
                        len_next = len_reg + 1'b1;
                    end
                end
                CMD_PIXEL: begin
                    if (is_embed) begin
                        ptr_next = ptr_emb;
                    end else begin
                        acc_next  = acc_x;
                        cnt_next  = cnt_x;
                        stop_next = stop_x;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_EMBED;
            len_reg  <= '0;
            ptr_reg  <= '0;
            acc_reg  <= 8'd0;
            cnt_reg  <= 3'd0;
            stop_reg <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
            ptr_reg  <= ptr_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            stop_reg <= stop_next;
        end
    end

    assign wr_en   = s_fire && (cmd == CMD_LOAD) && room;
    assign wr_addr = len_reg[ADDR_W-1:0];
    assign wr_data = msg_byte;

    assign issue = s_fire && (cmd == CMD_PIXEL);
    assign rd_en = issue;

    always_comb begin
        meta.n_bits     = is_embed ? n_emb : 2'd0;
        meta.bit_off    = ptr_reg[2:0];
        meta.red        = red;
        meta.green      = green;
        meta.blue       = blue;
        meta.byte_valid = !is_embed && xv;
        meta.rbyte      = is_embed ? 8'd0 : xb;
        meta.mend       = !is_embed && xm;
        meta.big        = is_embed && big;
        meta.perr       = !is_embed && xp;
    end

endmodule

[design/lse_out_stage.sv]
// bit substitution after the store read, and the output register
module lse_out_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          issue,
    input  lse_pkg::lse_meta_t            meta,
    input  logic [7:0]                    rd_data_a,
    input  logic [7:0]                    rd_data_b,
    input  logic                          m_tready,
    output logic                          can_issue,
    output logic                          m_tvalid,
    output logic [lse_pkg::M_DATA_W-1:0]  m_tdata,
    output logic [0:0]                    m_tuser
);
    import lse_pkg::*;

    logic          s1_valid_reg;
    lse_meta_t     s1_meta_reg;
    logic          out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic          out_user_reg;
    logic          s1_adv;

    logic [15:0] word;
    logic [7:0]  ch_in  [3];
    logic [7:0]  ch_out [3];
    logic [3:0]  pos;
    logic        bit_val;

    assign s1_adv    = !out_valid_reg || m_tready;
    assign can_issue = !s1_valid_reg || s1_adv;

    assign word     = {rd_data_a, rd_data_b};
    assign ch_in[0] = s1_meta_reg.red;
    assign ch_in[1] = s1_meta_reg.green;
    assign ch_in[2] = s1_meta_reg.blue;

    // message bits are taken msb first from the two-byte window
    always_comb begin
        pos     = 4'd0;
        bit_val = 1'b0;
        for (int k = 0; k < 3; k++) begin
            pos     = 4'd15 - 4'(s1_meta_reg.bit_off) - 4'(k);
            bit_val = word[pos];
            if (2'(k) < s1_meta_reg.n_bits) begin
                ch_out[k] = (ch_in[k] & LSB_CLEAR) | {7'd0, bit_val};
            end else begin
                ch_out[k] = ch_in[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (can_issue) begin
                s1_valid_reg <= issue;
            end
            if (s1_adv) begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            s1_meta_reg <= meta;
        end
        if (s1_adv && s1_valid_reg) begin
            out_data_reg <= {5'd0, s1_meta_reg.perr, s1_meta_reg.big, s1_meta_reg.mend,
                             s1_meta_reg.rbyte, ch_out[2], ch_out[1], ch_out[0]};
            out_user_reg <= s1_meta_reg.byte_valid;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_user_reg;

endmodule

[design/lsb_stego_embed_extract_unit.sv]
// lsb steganography embed/extract unit, top level
// a pixel item's result is registered in the store read, then in the output register
// one item per cycle sustained while the output is not stalled; start and load items give no result
// the message store has one write and two read ports, so a pixel straddling bytes reads both bytes together
// reset clears mode, pointers, accumulator and the stop flag; the store keeps its contents
module lsb_stego_embed_extract_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // message_byte[7:0], red_in[15:8], green_in[23:16], blue_in[31:24]
    input  logic [lse_pkg::S_DATA_W-1:0]  s_tdata,
    // command[1:0]
    input  logic [lse_pkg::CMD_W-1:0]     s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // red_out[7:0], green_out[15:8], blue_out[23:16], recovered_byte[31:24],
    // message_end[32], too_large[33], partial_error[34], zero[39:35]
    output logic [lse_pkg::M_DATA_W-1:0]  m_tdata,
    // byte_valid[0]
    output logic [0:0]                    m_tuser
);
    import lse_pkg::*;

    logic              s_fire;
    logic              can_issue;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic [7:0]        rd_data_a;
    logic [7:0]        rd_data_b;
    logic              issue;
    lse_meta_t         meta;

    assign cfg_ready = 1'b1;
    assign s_tready  = can_issue;
    assign s_fire    = s_tvalid && s_tready;

    lse_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_fire    (s_fire),
        .cmd       (s_tuser),
        .msg_byte  (s_tdata[7:0]),
        .red       (s_tdata[15:8]),
        .green     (s_tdata[23:16]),
        .blue      (s_tdata[31:24]),
        .last      (s_tlast),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .issue     (issue),
        .meta      (meta)
    );

    lse_msg_ram u_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    lse_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .issue     (issue),
        .meta      (meta),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .m_tready  (m_tready),
        .can_issue (can_issue),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

[design/lse_checker.sv]
// port-level checks for the lsb steganography unit, bound to the top level
`include "lsb_stego_embed_extract_unit_defines.svh"

module lse_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lse_pkg::M_DATA_W-1:0]  m_tdata,
    input logic [0:0]                    m_tuser
);
    import lse_pkg::*;

    logic [7:0] rec_byte;

    assign rec_byte = m_tdata[31:24];

    `LSE_ASSERT_RST(a_reset_idle, !aresetn, !m_tvalid)

    `LSE_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // a reported byte is printable, otherwise the byte field is zero
    `LSE_ASSERT_IMPL(a_byte_print, m_tvalid && m_tuser[0], is_printable(rec_byte))

    `LSE_ASSERT_IMPL(a_byte_zero, m_tvalid && !m_tuser[0], rec_byte == 8'd0)

    // embed flag excludes every extract flag
    `LSE_ASSERT_IMPL(a_mode_flags, m_tvalid && m_tdata[33], !m_tuser[0] && !m_tdata[32] && !m_tdata[34])

endmodule

bind lsb_stego_embed_extract_unit lse_checker u_lse_checker (.*);
